/* rtl/core/bwlf_pkg.sv */
// Shared types and constants for the boundary wire line follower.
// Used by bwlf_step and boundary_wire_line_follower_unit; no dependencies.
package bwlf_pkg;

    // Follow modes, one-hot
    typedef enum logic [5:0] {
        MODE_IDLE     = 6'b000001,
        MODE_START    = 6'b000010,
        MODE_FINDDIR  = 6'b000100,
        MODE_GOTOLINE = 6'b001000,
        MODE_FINDLINE = 6'b010000,
        MODE_TRACE    = 6'b100000
    } t_mode;

    // Mode codes as reported in the result word
    localparam logic [2:0] MODE_CODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_CODE_START    = 3'd1;
    localparam logic [2:0] MODE_CODE_FINDDIR  = 3'd2;
    localparam logic [2:0] MODE_CODE_GOTOLINE = 3'd3;
    localparam logic [2:0] MODE_CODE_FINDLINE = 3'd4;
    localparam logic [2:0] MODE_CODE_TRACE    = 3'd5;

    typedef logic [1:0] t_side;
    localparam t_side SIDE_MISSING = 2'd0;
    localparam t_side SIDE_INSIDE  = 2'd1;
    localparam t_side SIDE_OUTSIDE = 2'd2;

    typedef logic [2:0] t_orient;
    localparam t_orient OR_NONE    = 3'd0;
    localparam t_orient OR_NORMAL  = 3'd1;
    localparam t_orient OR_LHIGH   = 3'd2;
    localparam t_orient OR_LLOW    = 3'd3;
    localparam t_orient OR_ALIGNED = 3'd4;
    localparam t_orient OR_REVERSE = 3'd5;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_TARGET_SPEED     = 2'd0;
    localparam logic [1:0] REG_LINE_DIRECTION   = 2'd1;
    localparam logic [1:0] REG_DETECT_THRESHOLD = 2'd2;

    localparam logic [15:0] THRESHOLD_RESET = 16'd1000;

    // floor(t/10) = (t * 52429) >> 19 and floor(t/5) = (t * 52429) >> 18, exact for 15-bit t
    localparam logic [15:0] RECIP_MUL = 16'd52429;

    typedef struct packed {
        logic [14:0] speed;
        logic [14:0] tenth;
        logic [14:0] fifth;
        logic        reverse;
        logic [15:0] threshold;
    } t_cfg;

    typedef struct packed {
        t_mode              mode;
        t_side              last_left;
        t_side              last_right;
        logic signed [15:0] angle;
        logic        [14:0] line;
        logic               lost;
    } t_state;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            MODE_START:    c = MODE_CODE_START;
            MODE_FINDDIR:  c = MODE_CODE_FINDDIR;
            MODE_GOTOLINE: c = MODE_CODE_GOTOLINE;
            MODE_FINDLINE: c = MODE_CODE_FINDLINE;
            MODE_TRACE:    c = MODE_CODE_TRACE;
            default:       c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/bwlf_step.sv */
// Next-state logic for one sample word: coil classification, orientation
// and follow-mode update. Purely combinational; depends on bwlf_pkg.
module bwlf_step #(
    parameter int READING_BITS = 17
) (
    input  bwlf_pkg::t_cfg                i_cfg,
    input  bwlf_pkg::t_state              i_state,
    input  logic                          i_command,
    input  logic signed [READING_BITS-1:0] i_left_raw,
    input  logic signed [READING_BITS-1:0] i_right_raw,
    output bwlf_pkg::t_state              o_state,
    output bwlf_pkg::t_orient             o_orient
);

    localparam int RB = READING_BITS;
    localparam int CW = (RB > 16) ? RB : 16;
    localparam int PW = RB + 4;

    logic [RB-1:0]      w_l_mag, w_r_mag;
    bwlf_pkg::t_side    w_sl, w_sr;
    logic [PW-1:0]      w_l10, w_l11, w_r10, w_r11;
    logic               w_normal, w_l_gt, w_l_lt;
    bwlf_pkg::t_orient  w_or;
    logic signed [15:0] w_t, w_t10, w_t5;
    logic               w_ccw;

    // Magnitude of each reading is used for the threshold: a positive raw value is outside.
    assign w_l_mag = i_left_raw[RB-1]  ? RB'(~i_left_raw + 1'b1)  : RB'(i_left_raw);
    assign w_r_mag = i_right_raw[RB-1] ? RB'(~i_right_raw + 1'b1) : RB'(i_right_raw);

    always_comb begin
        if (CW'(w_l_mag) < CW'(i_cfg.threshold)) begin
            w_sl = bwlf_pkg::SIDE_MISSING;
        end else if (i_left_raw[RB-1] || (i_left_raw == '0)) begin
            w_sl = bwlf_pkg::SIDE_INSIDE;
        end else begin
            w_sl = bwlf_pkg::SIDE_OUTSIDE;
        end
        if (CW'(w_r_mag) < CW'(i_cfg.threshold)) begin
            w_sr = bwlf_pkg::SIDE_MISSING;
        end else if (i_right_raw[RB-1] || (i_right_raw == '0)) begin
            w_sr = bwlf_pkg::SIDE_INSIDE;
        end else begin
            w_sr = bwlf_pkg::SIDE_OUTSIDE;
        end
    end

    // 10x and 11x by shift-add for the 10% margin test
    assign w_l10 = (PW'(w_l_mag) << 3) + (PW'(w_l_mag) << 1);
    assign w_l11 = w_l10 + PW'(w_l_mag);
    assign w_r10 = (PW'(w_r_mag) << 3) + (PW'(w_r_mag) << 1);
    assign w_r11 = w_r10 + PW'(w_r_mag);
    assign w_normal = (w_l10 < w_r11) && (w_r10 < w_l11);
    assign w_l_gt = w_l_mag > w_r_mag;
    assign w_l_lt = w_l_mag < w_r_mag;

    always_comb begin
        if (w_sl == w_sr) begin
            if (w_normal) begin
                w_or = bwlf_pkg::OR_NORMAL;
            end else begin
                w_or = w_l_gt ? bwlf_pkg::OR_LHIGH : bwlf_pkg::OR_LLOW;
            end
        end else if ((w_sl == bwlf_pkg::SIDE_INSIDE) ^ i_cfg.reverse) begin
            w_or = bwlf_pkg::OR_ALIGNED;
        end else begin
            w_or = bwlf_pkg::OR_REVERSE;
        end
    end

    assign w_t   = $signed({1'b0, i_cfg.speed});
    assign w_t10 = $signed({1'b0, i_cfg.tenth});
    assign w_t5  = $signed({1'b0, i_cfg.fifth});
    assign w_ccw = (w_sl == bwlf_pkg::SIDE_OUTSIDE) ^ i_cfg.reverse;

    always_comb begin
        o_state  = i_state;
        o_orient = bwlf_pkg::OR_NONE;
        if (i_command) begin
            o_state.mode = bwlf_pkg::MODE_START;
        end else if ((w_sl == bwlf_pkg::SIDE_MISSING) || (w_sr == bwlf_pkg::SIDE_MISSING)) begin
            o_state.lost = 1'b1;
        end else begin
            o_orient = w_or;
            case (i_state.mode)
                bwlf_pkg::MODE_START: begin
                    if (w_or == bwlf_pkg::OR_NORMAL) begin
                        o_state.last_left  = w_sl;
                        o_state.last_right = w_sr;
                        o_state.mode       = bwlf_pkg::MODE_GOTOLINE;
                    end else if ((w_or == bwlf_pkg::OR_LHIGH) || (w_or == bwlf_pkg::OR_LLOW)) begin
                        o_state.mode = bwlf_pkg::MODE_FINDDIR;
                    end else if (w_or == bwlf_pkg::OR_ALIGNED) begin
                        o_state.mode = bwlf_pkg::MODE_TRACE;
                    end else begin
                        o_state.mode = bwlf_pkg::MODE_FINDLINE;
                    end
                    o_state.angle = '0;
                    o_state.line  = '0;
                end
                bwlf_pkg::MODE_FINDDIR, bwlf_pkg::MODE_FINDLINE: begin
                    o_state.line = '0;
                    if (w_or == bwlf_pkg::OR_LHIGH) begin
                        o_state.angle = w_t;
                    end else if (w_or == bwlf_pkg::OR_LLOW) begin
                        o_state.angle = -w_t;
                    end else begin
                        o_state.mode  = bwlf_pkg::MODE_START;
                        o_state.angle = '0;
                    end
                end
                bwlf_pkg::MODE_GOTOLINE: begin
                    if ((i_state.last_left != w_sl) || (i_state.last_right != w_sr)
                        || (w_sl != w_sr)) begin
                        o_state.mode = (w_or == bwlf_pkg::OR_ALIGNED) ?
                                       bwlf_pkg::MODE_TRACE : bwlf_pkg::MODE_FINDLINE;
                    end
                    // equal magnitudes keep the previous turn
                    if (w_l_gt) begin
                        o_state.angle = w_t10;
                    end else if (w_l_lt) begin
                        o_state.angle = -w_t10;
                    end
                    o_state.line       = i_cfg.speed;
                    o_state.last_left  = w_sl;
                    o_state.last_right = w_sr;
                end
                bwlf_pkg::MODE_TRACE: begin
                    if (w_sl == w_sr) begin
                        o_state.angle = w_ccw ? w_t : -w_t;
                    end else if (w_l_lt) begin
                        o_state.angle = -w_t5;
                    end else if (w_l_gt) begin
                        o_state.angle = w_t5;
                    end else begin
                        o_state.angle = '0;
                    end
                    o_state.line = i_cfg.speed;
                end
                default: begin
                    o_state.angle = '0;
                    o_state.line  = '0;
                end
            endcase
        end
    end

endmodule

/* rtl/core/boundary_wire_line_follower_unit.sv */
// Top level of the boundary wire line follower: stream ports, APB register
// file, input and result registers. Depends on bwlf_pkg and bwlf_step.

// One sample word in, one result word out. A word is taken every cycle
// when the output side keeps up. Each word goes into the input register at
// the input handshake edge and moves on into the result register, where
// the result is valid. Mode and held speeds are updated as a word moves
// from the input register to the result register, which is what sets the
// one-word-per-cycle rate. A stalled output holds one word in each
// register before s_axis tready drops. Registers may only be written
// while no word is in flight.
module boundary_wire_line_follower_unit #(
    parameter int READING_BITS = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: left_raw [RB-1:0], right_raw [2*RB-1:RB], zero padding above
    input  logic [((2*READING_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: command (0 sample, 1 start)
    input  logic                  i_s_axis_tuser,
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: angle_speed [15:0], line_speed [30:16], left_motor [47:31],
    // right_motor [64:48], mode [67:65], orientation [70:68], no_line_error [71]
    output logic [71:0]           o_m_axis_tdata,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int RB = READING_BITS;

    bwlf_pkg::t_cfg    r_cfg;
    bwlf_pkg::t_state  r_state, n_state;
    bwlf_pkg::t_orient w_orient;

    logic                 r_in_valid;
    logic                 r_in_cmd;
    logic signed [RB-1:0] r_in_left, r_in_right;
    logic                 r_out_valid;
    logic [71:0]          r_out_data;

    logic        w_out_adv;
    logic        w_cfg_wr;
    logic [30:0] w_recip;
    logic signed [16:0] w_left_motor, w_right_motor;

    // ---------------- register port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_recip  = 31'(pwdata[14:0]) * 31'(bwlf_pkg::RECIP_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed     <= '0;
            r_cfg.tenth     <= '0;
            r_cfg.fifth     <= '0;
            r_cfg.reverse   <= 1'b0;
            r_cfg.threshold <= bwlf_pkg::THRESHOLD_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                bwlf_pkg::REG_TARGET_SPEED: begin
                    r_cfg.speed <= pwdata[14:0];
                    // scaled speeds precomputed here, out of the sample path
                    r_cfg.tenth <= 15'(w_recip[30:19]);
                    r_cfg.fifth <= 15'(w_recip[30:18]);
                end
                bwlf_pkg::REG_LINE_DIRECTION:   r_cfg.reverse   <= pwdata[0];
                bwlf_pkg::REG_DETECT_THRESHOLD: r_cfg.threshold <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bwlf_pkg::REG_TARGET_SPEED:     prdata = {17'd0, r_cfg.speed};
            bwlf_pkg::REG_LINE_DIRECTION:   prdata = {31'd0, r_cfg.reverse};
            bwlf_pkg::REG_DETECT_THRESHOLD: prdata = {16'd0, r_cfg.threshold};
            default:                        prdata = '0;
        endcase
    end

    // ---------------- data path ----------------
    assign w_out_adv       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_out_adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    bwlf_step #(
        .READING_BITS (RB)
    ) u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_command   (r_in_cmd),
        .i_left_raw  (r_in_left),
        .i_right_raw (r_in_right),
        .o_state     (n_state),
        .o_orient    (w_orient)
    );

    assign w_left_motor  = $signed({2'b00, n_state.line}) + 17'(n_state.angle);
    assign w_right_motor = $signed({2'b00, n_state.line}) - 17'(n_state.angle);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_state.mode       <= bwlf_pkg::MODE_IDLE;
            r_state.last_left  <= bwlf_pkg::SIDE_MISSING;
            r_state.last_right <= bwlf_pkg::SIDE_MISSING;
            r_state.angle      <= '0;
            r_state.line       <= '0;
            r_state.lost       <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd   <= i_s_axis_tuser;
            r_in_left  <= i_s_axis_tdata[RB-1:0];
            r_in_right <= i_s_axis_tdata[2*RB-1:RB];
        end
        if (w_out_adv && r_in_valid) begin
            r_out_data <= {n_state.lost, w_orient, bwlf_pkg::mode_code(n_state.mode),
                           w_right_motor, w_left_motor, n_state.line, n_state.angle};
        end
    end

endmodule
